// ===== hdl/lppd_pkg.sv =====
// lppd_pkg: shared types and constants for the length-prefixed pdu deframer
// no dependencies; used by the interfaces, the framing calc and the core
package lppd_pkg;

  // field widths fixed by the stream format
  localparam int unsigned POS_W  = 17;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned BYTE_W = 8;

  // default header size in bytes
  localparam int unsigned HEADER_BYTES_DEF = 24;

  // header byte positions holding the little-endian payload length
  localparam logic [POS_W-1:0] LEN_LO_POS = POS_W'(2);
  localparam logic [POS_W-1:0] LEN_HI_POS = POS_W'(3);

  // action codes
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_GAP  = 1'b1;

  // one input transaction
  typedef struct packed {
    logic              action;
    logic              direction;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              out_direction;
    logic              pdu_first;
    logic              pdu_last;
    logic [POS_W-1:0]  byte_offset;
    logic              pdu_abort;
  } out_item_t;

  // per-direction framing state
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } dir_state_t;

endpackage

// ===== hdl/lppd_if.sv =====
// lppd_if: valid/ready channel interfaces for input bytes and framed results
// depends on lppd_pkg for field widths
interface lppd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic                         direction;
  logic [lppd_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output action, output direction, output data_byte,
                  input ready);
  modport sink   (input valid, input action, input direction, input data_byte,
                  output ready);
endinterface

interface lppd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         byte_valid;
  logic [lppd_pkg::BYTE_W-1:0]  out_byte;
  logic                         out_direction;
  logic                         pdu_first;
  logic                         pdu_last;
  logic [lppd_pkg::POS_W-1:0]   byte_offset;
  logic                         pdu_abort;

  modport source (output valid, output byte_valid, output out_byte, output out_direction,
                  output pdu_first, output pdu_last, output byte_offset,
                  output pdu_abort, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input out_direction,
                  input pdu_first, input pdu_last, input byte_offset,
                  input pdu_abort, output ready);
endinterface

// ===== hdl/length_prefixed_pdu_deframer_core.sv =====
// length_prefixed_pdu_deframer_core: two-direction byte deframer, top level
// depends on lppd_pkg, lppd_if and lppd_frame_calc
// an input transaction passes through the input register and then the result register on its way to a result
// throughput: one byte per cycle, either direction, sustained while the sink takes results
// the per-direction position/length update is a single combinational step between registers
// reset (synchronous, rst_n low) clears both directions' position and length and empties both stages
module length_prefixed_pdu_deframer_core #(
  parameter int unsigned HEADER_BYTES = lppd_pkg::HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lppd_in_if.sink           in_ch,
  lppd_out_if.source        out_ch
);

  lppd_pkg::in_item_t    in_item_r;
  logic                  in_vld_r;
  lppd_pkg::out_item_t   out_item_r;
  logic                  out_vld_r;
  lppd_pkg::dir_state_t  st_r [2];

  lppd_pkg::dir_state_t  cur_st;
  lppd_pkg::dir_state_t  st_nxt;
  lppd_pkg::out_item_t   res;
  logic                  adv;
  logic                  in_take;

  // stage handshake
  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.action    <= in_ch.action;
      in_item_r.direction <= in_ch.direction;
      in_item_r.data_byte <= in_ch.data_byte;
    end
  end

  // state of the item's direction
  assign cur_st = st_r[in_item_r.direction];

  lppd_frame_calc #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_calc (
    .item(in_item_r),
    .cur (cur_st),
    .res (res),
    .nxt (st_nxt)
  );

  // per-direction state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0] <= '0;
      st_r[1] <= '0;
    end else if (adv) begin
      st_r[in_item_r.direction] <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res;
    end
  end

  // output ports
  assign out_ch.valid         = out_vld_r;
  assign out_ch.byte_valid    = out_item_r.byte_valid;
  assign out_ch.out_byte      = out_item_r.out_byte;
  assign out_ch.out_direction = out_item_r.out_direction;
  assign out_ch.pdu_first     = out_item_r.pdu_first;
  assign out_ch.pdu_last      = out_item_r.pdu_last;
  assign out_ch.byte_offset   = out_item_r.byte_offset;
  assign out_ch.pdu_abort     = out_item_r.pdu_abort;

`ifndef SYNTHESIS
  // a processed gap leaves its direction at position zero
  a_gap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_item_r.action == lppd_pkg::ACT_GAP)
    |=> st_r[$past(in_item_r.direction)].pos == '0)
    else $error("gap did not clear direction position");

  // a pdu end restarts its direction at position zero
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.pdu_last |=> st_r[$past(in_item_r.direction)].pos == '0)
    else $error("pdu end did not restart position");

  // a processed item always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r && (out_item_r.out_direction == $past(in_item_r.direction)))
    else $error("result register not loaded");

  // an abort never comes with a valid byte
  a_abort_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.pdu_abort |-> !out_item_r.byte_valid && !out_item_r.pdu_last)
    else $error("abort flagged on a data byte");
`endif

endmodule

// ===== hdl/lppd_frame_calc.sv =====
// lppd_frame_calc: combinational framing step for one byte of one direction
// depends on lppd_pkg; computes the result and the direction's next state
module lppd_frame_calc #(
  parameter int unsigned HEADER_BYTES = lppd_pkg::HEADER_BYTES_DEF
) (
  input  lppd_pkg::in_item_t   item,
  input  lppd_pkg::dir_state_t cur,
  output lppd_pkg::out_item_t  res,
  output lppd_pkg::dir_state_t nxt
);

  localparam logic [lppd_pkg::POS_W-1:0] HDR_END = lppd_pkg::POS_W'(HEADER_BYTES - 1);

  logic                         is_gap;
  logic [lppd_pkg::LEN_W-1:0]   len_upd;
  logic [lppd_pkg::POS_W-1:0]   end_pos;
  logic                         last;

  // capture length bytes from header positions two and three
  always_comb begin
    len_upd = cur.len;
    if (cur.pos == lppd_pkg::LEN_LO_POS) begin
      len_upd = {cur.len[lppd_pkg::LEN_W-1:8], item.data_byte};
    end else if (cur.pos == lppd_pkg::LEN_HI_POS) begin
      len_upd = {item.data_byte, cur.len[7:0]};
    end
  end

  // end of pdu: header end plus payload length, fits in the offset width
  assign is_gap  = (item.action == lppd_pkg::ACT_GAP);
  assign end_pos = HDR_END + lppd_pkg::POS_W'(len_upd);
  assign last    = (cur.pos >= HDR_END) && (cur.pos == end_pos);

  // result and next state
  always_comb begin
    res.out_direction = item.direction;
    if (is_gap) begin
      res.byte_valid  = 1'b0;
      res.out_byte    = '0;
      res.pdu_first   = 1'b0;
      res.pdu_last    = 1'b0;
      res.byte_offset = '0;
      res.pdu_abort   = (cur.pos != '0);
      nxt.pos         = '0;
      nxt.len         = '0;
    end else begin
      res.byte_valid  = 1'b1;
      res.out_byte    = item.data_byte;
      res.pdu_first   = (cur.pos == '0);
      res.pdu_last    = last;
      res.byte_offset = cur.pos;
      res.pdu_abort   = 1'b0;
      nxt.pos         = last ? '0 : cur.pos + lppd_pkg::POS_W'(1);
      nxt.len         = len_upd;
    end
  end

endmodule

// ===== dv/tb_length_prefixed_pdu_deframer_core.sv =====
`timescale 1ns / 1ps
// tb_length_prefixed_pdu_deframer_core: self-checking bench for the two-direction pdu deframer
// depends on lppd_pkg, lppd_if and the length_prefixed_pdu_deframer_core rtl
// directed pdu cases, a maximum-length pdu cut short, a long sink hold-off and mixed traffic
module tb_length_prefixed_pdu_deframer_core;

  localparam int unsigned HEADER_BYTES = lppd_pkg::HEADER_BYTES_DEF;
  localparam logic [lppd_pkg::POS_W-1:0] HDR_END = lppd_pkg::POS_W'(HEADER_BYTES - 1);
  localparam int unsigned MAX_LEN = 16'hFFFF;
  localparam int unsigned MAX_CUT_PAYLOAD = 60;
  localparam int unsigned MIXED_ITEMS = 250;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 50;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum int unsigned {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;

  lppd_in_if  in_ch();
  lppd_out_if out_ch();

  length_prefixed_pdu_deframer_core #(
    .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // framing state per direction, mirrors the block
  logic [lppd_pkg::POS_W-1:0] rx_pos [2];
  logic [lppd_pkg::LEN_W-1:0] rx_len [2];

  lppd_pkg::out_item_t framed_q[$];
  lppd_pkg::out_item_t exp_item;
  lppd_pkg::in_item_t  pdu_stream[2][$];
  int unsigned         fault_count;
  int unsigned         idle_cycles;
  int unsigned         burst_left;
  bit                  sender_idle;
  bit                  hold_go;
  rx_mode_t            rx_mode;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // expected result for one byte or gap, advances the framing state
  function automatic lppd_pkg::out_item_t frame_byte(lppd_pkg::in_item_t it);
    lppd_pkg::out_item_t        r;
    logic                       d;
    logic [lppd_pkg::POS_W-1:0] p;
    logic                       is_last;
    d = it.direction;
    p = rx_pos[d];
    r = '0;
    r.out_direction = d;
    if (it.action == lppd_pkg::ACT_GAP) begin
      r.pdu_abort = (p != '0);
      rx_pos[d] = '0;
      rx_len[d] = '0;
      return r;
    end
    if (p == lppd_pkg::LEN_LO_POS) begin
      rx_len[d][7:0] = it.data_byte;
    end else if (p == lppd_pkg::LEN_HI_POS) begin
      rx_len[d][15:8] = it.data_byte;
    end
    is_last = (p >= HDR_END) && (p == HDR_END + lppd_pkg::POS_W'(rx_len[d]));
    r.byte_valid  = 1'b1;
    r.out_byte    = it.data_byte;
    r.pdu_first   = (p == '0);
    r.pdu_last    = is_last;
    r.byte_offset = p;
    rx_pos[d] = is_last ? '0 : p + lppd_pkg::POS_W'(1);
    return r;
  endfunction

  function automatic lppd_pkg::in_item_t make_item(logic act, logic d,
                                                   logic [lppd_pkg::BYTE_W-1:0] b);
    lppd_pkg::in_item_t it;
    it.action    = act;
    it.direction = d;
    it.data_byte = b;
    return it;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  // scoreboard: check results first, then record the transaction taken in
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (framed_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("%0t ns: result with nothing outstanding, expected none actual byte %0h dir %0d",
                   $time, out_ch.out_byte, out_ch.out_direction);
        end
      end else begin
        exp_item = framed_q.pop_front();
        check_field("byte_valid", exp_item.byte_valid, out_ch.byte_valid);
        check_field("out_byte", exp_item.out_byte, out_ch.out_byte);
        check_field("out_direction", exp_item.out_direction, out_ch.out_direction);
        check_field("pdu_first", exp_item.pdu_first, out_ch.pdu_first);
        check_field("pdu_last", exp_item.pdu_last, out_ch.pdu_last);
        check_field("byte_offset", exp_item.byte_offset, out_ch.byte_offset);
        check_field("pdu_abort", exp_item.pdu_abort, out_ch.pdu_abort);
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      framed_q.push_back(frame_byte(make_item(in_ch.action, in_ch.direction, in_ch.data_byte)));
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_length_prefixed_pdu_deframer_core NOT OK");
      $finish;
    end
  end

  // result sink: stall pattern per mode, plus the long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned stall_phase;
    hold_left = 0;
    stall_phase = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      stall_phase = (stall_phase == 4) ? 0 : stall_phase + 1;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ch.ready <= (stall_phase >= 2);
          default:    out_ch.ready <= ($urandom_range(0, 9) < 4);
        endcase
      end
    end
  end

  // offer one transaction, idling between bursts when enabled
  task automatic send_item(lppd_pkg::in_item_t it);
    int unsigned gap;
    if (sender_idle && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= it.action;
    in_ch.direction <= it.direction;
    in_ch.data_byte <= it.data_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic send_byte(logic d, logic [lppd_pkg::BYTE_W-1:0] b);
    send_item(make_item(lppd_pkg::ACT_DATA, d, b));
  endtask

  task automatic send_gap(logic d);
    send_item(make_item(lppd_pkg::ACT_GAP, d, lppd_pkg::BYTE_W'($urandom_range(0, 255))));
  endtask

  task automatic set_traffic(bit idle_en, rx_mode_t mode);
    sender_idle = idle_en;
    rx_mode = mode;
  endtask

  // queue the next chunk of one direction: a lone gap, a cut pdu, or a whole pdu
  task automatic queue_pdu(logic d);
    int unsigned                 kind;
    int unsigned                 nbytes;
    int unsigned                 i;
    logic [lppd_pkg::LEN_W-1:0]  plen;
    logic [lppd_pkg::BYTE_W-1:0] b;
    bit                          broken;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      pdu_stream[d].push_back(make_item(lppd_pkg::ACT_GAP, d,
                                        lppd_pkg::BYTE_W'($urandom_range(0, 255))));
      return;
    end
    broken = (kind < 18);
    if (broken) begin
      plen = lppd_pkg::LEN_W'($urandom_range(0, MAX_LEN));
      nbytes = $urandom_range(1, 40);
    end else begin
      plen = ($urandom_range(0, 99) < 85) ? lppd_pkg::LEN_W'($urandom_range(0, 16))
                                          : lppd_pkg::LEN_W'($urandom_range(17, 200));
      nbytes = HEADER_BYTES + plen;
    end
    for (i = 0; i < nbytes; i++) begin
      if (i == lppd_pkg::LEN_LO_POS) b = plen[7:0];
      else if (i == lppd_pkg::LEN_HI_POS) b = plen[15:8];
      else b = lppd_pkg::BYTE_W'($urandom_range(0, 255));
      pdu_stream[d].push_back(make_item(lppd_pkg::ACT_DATA, d, b));
    end
    if (broken) begin
      pdu_stream[d].push_back(make_item(lppd_pkg::ACT_GAP, d,
                                        lppd_pkg::BYTE_W'($urandom_range(0, 255))));
    end
  endtask

  // both directions interleaved at random, each carrying its own pdu sequence
  task automatic run_mixed_traffic(int unsigned n_items);
    int unsigned sent;
    logic        d;
    for (sent = 0; sent < n_items; sent++) begin
      d = 1'($urandom_range(0, 1));
      if (pdu_stream[d].size() == 0) queue_pdu(d);
      send_item(pdu_stream[d].pop_front());
    end
  endtask

  // gap with nothing open gives no abort
  task automatic test_gap_when_idle();
    set_traffic(1'b1, RX_RANDOM);
    send_gap(1'b0);
    send_gap(1'b1);
  endtask

  // zero length: last mark on the final header byte, then a gap at a boundary
  task automatic test_header_only_pdu();
    int unsigned i;
    set_traffic(1'b1, RX_RANDOM);
    for (i = 0; i < HEADER_BYTES; i++) begin
      if (i == lppd_pkg::LEN_LO_POS || i == lppd_pkg::LEN_HI_POS) send_byte(1'b0, 8'h00);
      else send_byte(1'b0, i[0] ? 8'hFF : 8'h00);
    end
    send_gap(1'b0);
  endtask

  // gap inside a header aborts that direction only
  task automatic test_partial_pdu_abort();
    set_traffic(1'b1, RX_PATTERN);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h5A);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h34);
    send_byte(1'b1, 8'h12);
    send_gap(1'b1);
    send_gap(1'b0);
  endtask

  // maximum payload length: no early last mark, then a gap aborts the open pdu
  task automatic test_max_length_cut();
    int unsigned i;
    set_traffic(1'b0, RX_ALWAYS);
    for (i = 0; i < HEADER_BYTES + MAX_CUT_PAYLOAD; i++) begin
      if (i == lppd_pkg::LEN_LO_POS || i == lppd_pkg::LEN_HI_POS) send_byte(1'b0, 8'hFF);
      else send_byte(1'b0, lppd_pkg::BYTE_W'($urandom_range(0, 255)));
    end
    send_gap(1'b0);
  endtask

  // sink holds off long enough that the block fills and stalls its input
  task automatic test_full_backpressure();
    set_traffic(1'b0, RX_ALWAYS);
    hold_go = 1'b1;
    run_mixed_traffic(80);
  endtask

  task automatic test_mixed_traffic();
    set_traffic(1'b1, RX_RANDOM);
    run_mixed_traffic(MIXED_ITEMS);
    set_traffic(1'b0, RX_ALWAYS);
    run_mixed_traffic(MIXED_ITEMS);
    set_traffic(1'b1, RX_PATTERN);
    run_mixed_traffic(MIXED_ITEMS);
    set_traffic(1'b0, RX_SPARSE);
    run_mixed_traffic(MIXED_ITEMS);
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = lppd_pkg::ACT_DATA;
    in_ch.direction = 1'b0;
    in_ch.data_byte = '0;
    rx_pos[0] = '0;
    rx_pos[1] = '0;
    rx_len[0] = '0;
    rx_len[1] = '0;
    fault_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    sender_idle = 1'b0;
    hold_go = 1'b0;
    rx_mode = RX_ALWAYS;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_gap_when_idle();
    test_header_only_pdu();
    test_partial_pdu_abort();
    test_max_length_cut();
    test_full_backpressure();
    test_mixed_traffic();

    // drain, then a few more cycles for anything stray
    in_ch.valid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_length_prefixed_pdu_deframer_core OK");
    end else begin
      $display("tb_length_prefixed_pdu_deframer_core NOT OK");
    end
    $finish;
  end

endmodule
